>>> rtl/olar_pkg.sv
// Shared types and constants for the ordered list core.
// Used by the controller, the datapath, the top level and the checker.
package olar_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_REMOVE,
    OP_DUMP_FWD,
    OP_DUMP_BWD
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic dump_next;
  } dp_cmd_t;

  typedef struct packed {
    logic out_last;
  } dp_stat_t;

endpackage

>>> rtl/olar_ctrl.sv
// Controller state machine of the ordered list core.
// Depends on olar_pkg; drives the handshakes and commands to olar_dpath.
module olar_ctrl import olar_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (stat.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/olar_dpath.sv
// Datapath of the ordered list core: entry cells, parallel compare,
// gap-closing shift, dump read pointer and result register. Depends on olar_pkg.
module olar_dpath import olar_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  op_t                      in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] out_value,
  output status_t                  out_status
);

  logic signed [DATA_W-1:0] cells_r [CAPACITY];
  logic [CNT_W-1:0]         count_r;
  op_t                      op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CAPACITY-1:0]      match_r;
  logic [CAPACITY-1:0]      pre;
  logic [IDX_W-1:0]         idx_r;
  logic [CNT_W-1:0]         rem_r;
  logic signed [DATA_W-1:0] out_val_r;
  status_t                  out_st_r;
  logic                     out_last_r;

  logic             full;
  logic             empty;
  logic             found;
  logic             do_append;
  logic             do_remove;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W-1:0] next_idx;
  logic [IDX_W-1:0] rd_idx;

  // prefix OR of the match vector: every cell at or after the first match shifts
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      acc    = acc | match_r[i];
      pre[i] = acc;
    end
  end

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign found     = pre[CAPACITY-1];
  assign do_append = cmd.exec && (op_r == OP_APPEND) && !full;
  assign do_remove = cmd.exec && (op_r == OP_REMOVE) && found;
  assign cnt_m1    = count_r - CNT_W'(1);
  assign first_idx = (op_r == OP_DUMP_FWD) ? '0 : cnt_m1[IDX_W-1:0];
  assign next_idx  = (op_r == OP_DUMP_FWD) ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
  assign rd_idx    = cmd.exec ? first_idx : next_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_append) begin
      count_r <= count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      cells_r[count_r[IDX_W-1:0]] <= val_r;
    end else if (do_remove) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (pre[i]) begin
          cells_r[i] <= cells_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      val_r <= in_value;
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= (cells_r[i] == in_value) && (CNT_W'(i) < count_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (op_r)
        OP_APPEND: begin
          out_val_r  <= val_r;
          out_st_r   <= full ? ST_FULL : ST_OK;
          out_last_r <= 1'b1;
        end
        OP_REMOVE: begin
          out_val_r  <= val_r;
          out_st_r   <= found ? ST_OK : ST_NOT_FOUND;
          out_last_r <= 1'b1;
        end
        default: begin
          if (empty) begin
            out_val_r  <= '0;
            out_st_r   <= ST_EMPTY;
            out_last_r <= 1'b1;
          end else begin
            out_val_r  <= cells_r[rd_idx];
            out_st_r   <= ST_OK;
            out_last_r <= (count_r == CNT_W'(1));
            idx_r      <= rd_idx;
            rem_r      <= cnt_m1;
          end
        end
      endcase
    end else if (cmd.dump_next) begin
      out_val_r  <= cells_r[rd_idx];
      out_last_r <= (rem_r == CNT_W'(1));
      idx_r      <= rd_idx;
      rem_r      <= rem_r - CNT_W'(1);
    end
  end

  assign stat.out_last = out_last_r;
  assign out_value     = out_val_r;
  assign out_status    = out_st_r;

endmodule

>>> rtl/ordered_list_append_remove_core.sv
// Top level of the ordered list core: stream ports, controller and datapath.
// Depends on olar_pkg, olar_ctrl and olar_dpath.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values. One item is
// in flight at a time: an accepted item is compared against all cells in
// parallel as it is taken, applied in the next (append, or removal with the
// later cells shifting toward the head), and its result is written to the
// output register at the same edge. Append and remove present one result,
// held until out_tready; a dump of N entries gives N results, one per cycle
// while out_tready is high (an empty dump gives one ST_EMPTY result). The
// next item is taken in the cycle after the last result is accepted.
module ordered_list_append_remove_core import olar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] out_value
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  logic signed [DATA_W-1:0] out_value;
  status_t                  out_status;

  olar_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  olar_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (op_t'(in_tuser)),
    .in_value   (signed'(in_tdata)),
    .stat       (stat),
    .out_value  (out_value),
    .out_status (out_status)
  );

  assign out_tdata = out_value;
  assign out_tuser = out_status;
  assign out_tlast = stat.out_last;

endmodule

>>> rtl/olar_checker.sv
// Port-level checks of the ordered list core, bound to the top level.
// Depends on olar_pkg and ordered_list_append_remove_core.
module olar_checker import olar_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // one item in flight: never ready while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after an accepted item");

  a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("dump stopped before its last item");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("not idle after the last result");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_EMPTY)) |-> (out_tlast && (out_tdata == '0)))
    else $error("empty dump result malformed");

endmodule

bind ordered_list_append_remove_core olar_checker u_olar_checker (.*);
